// ----- rtl/bps_pkg.sv -----
// Shared types, constants and table functions for the partition sum core.
package bps_pkg;

	localparam int SUM_FRAC_BITS_DEF  = 24;
	localparam int EXP_TABLE_BITS_DEF = 6;

	localparam int SUM_W   = 48;
	localparam int TEMP_W  = 16;
	localparam int ENERGY_W = 24;
	localparam int JQ_W    = 10;
	localparam int INV_W   = 32;
	localparam int MANT_W  = 31;
	localparam int FRAC_W  = 30;
	localparam int IP_W    = 18;

	localparam logic [31:0] KQ30       = 32'd2228783405;
	localparam logic [29:0] LN2Q30     = 30'd744261118;
	localparam logic [30:0] ONEQ30     = 31'h4000_0000;
	localparam logic [15:0] TEMP_RESET = 16'd1000;
	localparam logic [31:0] INV_RESET  = 32'd2228783;

	localparam logic REG_TEMPERATURE = 1'b0;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIV,
		ST_MULY,
		ST_TAB,
		ST_MULA,
		ST_MULAA,
		ST_MULP,
		ST_MULT,
		ST_SHIFT,
		ST_ACC
	} state_t;

	// floor square root, bit by bit
	function automatic logic [63:0] isqrt64(input logic [63:0] val);
		logic [63:0] v;
		logic [63:0] res;
		logic [63:0] b;
		v   = val;
		res = '0;
		b   = 64'h4000_0000_0000_0000;
		for (int i = 0; i < 32; i++) begin
			if (v >= res + b) begin
				v   = v - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	// 2^(-2^-k) in Q30 by repeated square roots
	function automatic logic [29:0] fac_entry(input int k);
		logic [63:0] v;
		v = isqrt64(64'h0800_0000_0000_0000);
		for (int i = 2; i <= k; i++)
			v = isqrt64(v << 30);
		return v[29:0];
	endfunction

endpackage

// ----- rtl/boltzmann_partition_sum_core.sv -----
// Boltzmann partition sum core: iterative fixed-point exp and accumulate.
//
// Each level runs from acceptance through the energy scaling, table, polynomial,
// degeneracy, shift and accumulate states to the sum update, and the block
// returns to idle before it takes the next level. The first level of a set
// first runs the restoring divider that forms 1/T. One 32x32 multiplier
// under the sequencer does the energy scaling, the table factors, the
// polynomial, and the degeneracy product, so the block takes one level at a
// time and holds in_stall high while it works. A temperature write takes
// effect at the next set. The result of a set appears on the level marked
// last and waits in an output register; a last level that finds that
// register still full holds until it drains.
module boltzmann_partition_sum_core #(
	parameter int SUM_FRAC_BITS  = bps_pkg::SUM_FRAC_BITS_DEF,
	parameter int EXP_TABLE_BITS = bps_pkg::EXP_TABLE_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [bps_pkg::ENERGY_W-1:0] level_energy,
	input  logic [bps_pkg::JQ_W-1:0]     rot_quantum,
	input  logic        last_level,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [bps_pkg::SUM_W-1:0]    partition_sum,
	output logic        sum_saturated
);
	import bps_pkg::*;

	localparam int R_W    = FRAC_W - EXP_TABLE_BITS;
	localparam int KC_W   = $clog2(EXP_TABLE_BITS);
	localparam int T_W    = 42;
	localparam int TERM_W = (SUM_FRAC_BITS > 30) ? T_W + SUM_FRAC_BITS - 30 : T_W;
	localparam int SH_OFS = 30 - SUM_FRAC_BITS;

	state_t state_q, state_d;

	logic [TEMP_W-1:0]   temp_q;
	logic                open_q;
	logic [INV_W-1:0]    inv_q;
	logic [ENERGY_W-1:0] e_q;
	logic [JQ_W-1:0]     j_q;
	logic                last_q;
	logic [31:0]         div_q;
	logic [TEMP_W-1:0]   rem_q;
	logic [TEMP_W-1:0]   tdiv_q;
	logic [4:0]          dcnt_q;
	logic [KC_W-1:0]     kc_q;
	logic [IP_W-1:0]     ip_q;
	logic [FRAC_W-1:0]   frac_q;
	logic [MANT_W-1:0]   m_q;
	logic [29:0]         a_q;
	logic [MANT_W-1:0]   p_q;
	logic [T_W-1:0]      t_q;
	logic [TERM_W-1:0]   term_q;
	logic [SUM_W-1:0]    sum_q;
	logic                sat_q;
	logic [SUM_W-1:0]    osum_q;
	logic                osat_q;

	logic [29:0] fac_w [EXP_TABLE_BITS];

	for (genvar g = 0; g < EXP_TABLE_BITS; g++) begin : g_fac
		assign fac_w[g] = fac_entry(g + 1);
	end

	// configuration port
	logic cfg_wr;
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_TEMPERATURE);
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_TEMPERATURE) ? {16'b0, temp_q} : 32'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_q <= TEMP_RESET;
		end else if (cfg_wr) begin
			temp_q <= pwdata[TEMP_W-1:0];
		end
	end

	// handshake
	logic in_acc, out_free, last_done;
	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign out_free  = !out_valid || !out_stall;
	assign last_done = (state_q == ST_ACC) && last_q && out_free;
	assign partition_sum = osum_q;
	assign sum_saturated = osat_q;

	// divider step
	logic [TEMP_W:0] remx;
	logic            qbit;
	logic [31:0]     div_nx;
	assign remx   = {rem_q, div_q[31]};
	assign qbit   = (remx >= {1'b0, tdiv_q});
	assign div_nx = {div_q[30:0], qbit};

	// shared multiplier
	logic [31:0] mul_a, mul_b;
	logic [63:0] prod;
	logic [4:0]  fidx;
	assign fidx = 5'(29 - int'(kc_q));

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_MULY: begin
				mul_a = inv_q;
				mul_b = 32'(e_q);
			end
			ST_TAB: begin
				mul_a = 32'(m_q);
				mul_b = 32'(fac_w[kc_q]);
			end
			ST_MULA: begin
				mul_a = 32'(frac_q[R_W-1:0]);
				mul_b = 32'(LN2Q30);
			end
			ST_MULAA: begin
				mul_a = 32'(a_q);
				mul_b = 32'(a_q);
			end
			ST_MULP: begin
				mul_a = 32'(m_q);
				mul_b = 32'(p_q);
			end
			ST_MULT: begin
				mul_a = 32'(m_q);
				mul_b = 32'({j_q, 1'b1});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end
	assign prod = 64'(mul_a) * 64'(mul_b);

	// scale shift and accumulate
	logic signed [19:0] sh_w;
	logic [5:0]         shl_w;
	logic [TERM_W-1:0]  term_w;
	logic [SUM_W:0]     acc_w;
	logic               ovf_w;
	assign sh_w  = signed'(20'(ip_q)) + 20'(SH_OFS);
	assign shl_w = 6'(-sh_w);
	always_comb begin
		if (sh_w[19])
			term_w = TERM_W'(t_q) << shl_w;
		else if (sh_w >= 20'sd64)
			term_w = '0;
		else
			term_w = TERM_W'(t_q >> sh_w[5:0]);
	end
	assign acc_w = {1'b0, sum_q} + (SUM_W + 1)'(term_q);
	// carry out of the add means the sum clamps
	assign ovf_w = acc_w[SUM_W];

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (in_acc) state_d = open_q ? ST_MULY : ST_DIV;
			ST_DIV:   if (dcnt_q == 5'd31) state_d = ST_MULY;
			ST_MULY:  state_d = ST_TAB;
			ST_TAB:   if (int'(kc_q) == EXP_TABLE_BITS - 1) state_d = ST_MULA;
			ST_MULA:  state_d = ST_MULAA;
			ST_MULAA: state_d = ST_MULP;
			ST_MULP:  state_d = ST_MULT;
			ST_MULT:  state_d = ST_SHIFT;
			ST_SHIFT: state_d = ST_ACC;
			ST_ACC:   if (!last_q || out_free) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q    <= 1'b0;
			inv_q     <= INV_RESET;
			sum_q     <= '0;
			sat_q     <= 1'b0;
			out_valid <= 1'b0;
			dcnt_q    <= '0;
			kc_q      <= '0;
		end else begin
			if (out_valid && !out_stall)
				out_valid <= 1'b0;
			if (state_q == ST_IDLE) begin
				dcnt_q <= '0;
				kc_q   <= '0;
			end
			if (state_q == ST_DIV) begin
				dcnt_q <= dcnt_q + 5'd1;
				if (dcnt_q == 5'd31) begin
					inv_q  <= div_nx;
					open_q <= 1'b1;
				end
			end
			if (state_q == ST_TAB)
				kc_q <= kc_q + KC_W'(1);
			if (state_q == ST_ACC && (!last_q || out_free)) begin
				if (last_done) begin
					out_valid <= 1'b1;
					open_q    <= 1'b0;
					sum_q     <= '0;
					sat_q     <= 1'b0;
				end else if (ovf_w) begin
					sum_q <= '1;
					sat_q <= 1'b1;
				end else begin
					sum_q <= acc_w[SUM_W-1:0];
				end
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			e_q    <= level_energy;
			j_q    <= rot_quantum;
			last_q <= last_level;
			div_q  <= KQ30 + 32'(temp_q >> 1);
			rem_q  <= '0;
			tdiv_q <= (temp_q == '0) ? TEMP_W'(1) : temp_q;
		end
		unique case (state_q)
			ST_DIV: begin
				div_q <= div_nx;
				rem_q <= qbit ? TEMP_W'(remx - {1'b0, tdiv_q}) : remx[TEMP_W-1:0];
			end
			ST_MULY: begin
				ip_q   <= prod[55:38];
				frac_q <= prod[37:8];
				m_q    <= ONEQ30;
			end
			ST_TAB: begin
				if (frac_q[fidx])
					m_q <= prod[60:30];
			end
			ST_MULA:  a_q <= prod[59:30];
			ST_MULAA: p_q <= ONEQ30 - MANT_W'(a_q) + prod[61:31];
			ST_MULP:  m_q <= prod[60:30];
			ST_MULT:  t_q <= prod[T_W-1:0];
			ST_SHIFT: term_q <= term_w;
			ST_ACC: begin
				if (last_done) begin
					osum_q <= ovf_w ? '1 : acc_w[SUM_W-1:0];
					osat_q <= ovf_w || sat_q;
				end
			end
			default: ;
		endcase
	end

endmodule

// ----- verif/tb.sv -----
// Testbench for the partition sum core: queued levels, in-line predictor, result checker.
`timescale 1ns / 100ps

module tb;
	import bps_pkg::*;

	typedef struct packed {
		logic [ENERGY_W-1:0] energy;
		logic [JQ_W-1:0]     jq;
		logic                last;
	} level_req_t;

	typedef struct packed {
		logic [SUM_W-1:0] sum;
		logic             sat;
	} sum_result_t;

	localparam logic [63:0] SUM_LIMIT = (64'd1 << SUM_W) - 64'd1;
	localparam int          SETTLE    = 80;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic in_valid = 1'b0, in_stall;
	logic out_valid, out_stall = 1'b0;
	logic [SUM_W-1:0] partition_sum;
	logic sum_saturated;
	level_req_t offered = '0;

	level_req_t levels_q[$];
	sum_result_t sums_q[$];
	int fails = 0;
	bit quiet = 1'b0;
	bit send_hold = 1'b0;
	bit long_hold_go = 1'b0;
	bit long_hold_done = 1'b0;
	int hold_cnt = 0;

	// predictor state
	logic [15:0] temp_reg = TEMP_RESET;
	logic [63:0] inv_temp = 64'(INV_RESET);
	logic [63:0] acc_sum = '0;
	bit acc_sat = 1'b0;
	bit set_open = 1'b0;
	logic [63:0] exp_fac[1:EXP_TABLE_BITS_DEF];

	always #5 clk = ~clk;

	boltzmann_partition_sum_core dut (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
		.in_valid, .in_stall,
		.level_energy(offered.energy), .rot_quantum(offered.jq), .last_level(offered.last),
		.out_valid, .out_stall, .partition_sum, .sum_saturated
	);

	function automatic logic [63:0] floor_sqrt(input logic [63:0] val);
		logic [63:0] v, root, b;
		v = val;
		root = '0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= root + b) begin
				v = v - (root + b);
				root = (root >> 1) + b;
			end else begin
				root = root >> 1;
			end
			b = b >> 2;
		end
		return root;
	endfunction

	function automatic logic [63:0] boltzmann_term(input logic [63:0] e, input logic [63:0] j);
		logic [63:0] y, ip, frac, m, r, a, p, t, sh;
		y = e * inv_temp;
		ip = y >> 38;
		frac = (y >> 8) & ((64'd1 << 30) - 1);
		m = 64'(ONEQ30);
		for (int k = 1; k <= EXP_TABLE_BITS_DEF; k++)
			if (frac[30-k]) m = (m * exp_fac[k]) >> 30;
		r = frac & ((64'd1 << (30 - EXP_TABLE_BITS_DEF)) - 1);
		a = (r * 64'(LN2Q30)) >> 30;
		p = 64'(ONEQ30) - a + ((a * a) >> 31);
		m = (m * p) >> 30;
		t = (2 * j + 1) * m;
		// integer part is never negative, so the shift is always to the right
		sh = ip + 30 - SUM_FRAC_BITS_DEF;
		if (sh >= 64) return '0;
		return t >> sh;
	endfunction

	function automatic void accumulate_level(input level_req_t lv);
		logic [63:0] t, term;
		if (!set_open) begin
			t = (temp_reg == 0) ? 64'd1 : 64'(temp_reg);
			inv_temp = ((64'(KQ30) + (t >> 1)) / t) & 64'hFFFF_FFFF;
			set_open = 1'b1;
		end
		term = boltzmann_term(64'(lv.energy), 64'(lv.jq));
		if (term > SUM_LIMIT - acc_sum) begin
			acc_sum = SUM_LIMIT;
			acc_sat = 1'b1;
		end else begin
			acc_sum = acc_sum + term;
		end
		if (lv.last) begin
			sums_q.insert(sums_q.size(),
				sum_result_t'{sum: acc_sum[SUM_W-1:0], sat: acc_sat});
			acc_sum = '0;
			acc_sat = 1'b0;
			set_open = 1'b0;
		end
	endfunction

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) accumulate_level(offered);
			if (!in_valid || !in_stall) begin
				if (levels_q.size() > 0 && !send_hold && (quiet || $urandom_range(0, 99) >= 10)) begin
					offered <= levels_q.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk or negedge arst_n) begin
		sum_result_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (sums_q.size() == 0) begin
					$error("result with nothing expected: sum=%0h sat=%0b", partition_sum,
						sum_saturated);
					fails++;
				end else begin
					want = sums_q.pop_front();
					if (partition_sum !== want.sum) begin
						$error("partition_sum: expected %0h, got %0h", want.sum, partition_sum);
						fails++;
					end
					if (sum_saturated !== want.sat) begin
						$error("sum_saturated: expected %0b, got %0b", want.sat, sum_saturated);
						fails++;
					end
				end
			end
			if (long_hold_go && !long_hold_done) begin
				long_hold_done <= 1'b1;
				hold_cnt <= 400;
				out_stall <= 1'b1;
			end else if (hold_cnt > 0) begin
				hold_cnt <= hold_cnt - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= !quiet && ($urandom_range(0, 99) < 10);
			end
		end
	end

	task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr == 3'(4 * REG_TEMPERATURE)) temp_reg = data[15:0];
	endtask

	task automatic wait_drained();
		while (levels_q.size() > 0 || in_valid || sums_q.size() > 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic queue_level(input logic [23:0] e, input logic [9:0] j, input logic l);
		levels_q.insert(levels_q.size(), level_req_t'{energy: e, jq: j, last: l});
	endtask

	task automatic queue_random_sets(input int n);
		int left, len;
		logic [23:0] e;
		left = n;
		while (left > 0) begin
			len = $urandom_range(1, 12);
			if (len > left) len = left;
			for (int i = 0; i < len; i++) begin
				case ($urandom_range(0, 3))
					0: e = 24'($urandom_range(0, 255));
					1: e = 24'($urandom_range(0, 65535));
					2: e = 24'($urandom_range(0, 1 << 20));
					default: e = 24'($urandom);
				endcase
				queue_level(e, 10'($urandom), i == len - 1);
			end
			left -= len;
		end
	endtask

	initial begin
		logic [15:0] temps[5];
		exp_fac[1] = floor_sqrt(64'd1 << 59);
		for (int k = 2; k <= EXP_TABLE_BITS_DEF; k++)
			exp_fac[k] = floor_sqrt(exp_fac[k-1] << 30);
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// directed: field extremes at the reset temperature
		queue_level(24'd0, 10'd0, 1'b1);
		queue_level(24'hFFFFFF, 10'h3FF, 1'b1);
		queue_level(24'd0, 10'h3FF, 1'b0);
		queue_level(24'd256, 10'd1, 1'b0);
		queue_level(24'hAAAAAA, 10'h155, 1'b1);
		queue_level(24'h555555, 10'h2AA, 1'b1);
		wait_drained();

		// unmapped register: ignored
		apb_write(3'd4, 32'd1);
		// temperature zero acts as one kelvin; huge shifts vanish
		apb_write(3'd0, 32'd0);
		queue_level(24'd0, 10'h3FF, 1'b0);
		queue_level(24'd1, 10'd7, 1'b0);
		queue_level(24'hFFFFFF, 10'h3FF, 1'b1);
		wait_drained();
		apb_write(3'd0, 32'd65535);
		queue_level(24'hFFFFFF, 10'h3FF, 1'b0);
		queue_level(24'h000100, 10'd0, 1'b1);
		wait_drained();

		// long set of maximum terms, back to back
		quiet = 1'b1;
		for (int i = 0; i < 40; i++) queue_level(24'd0, 10'h3FF, i == 39);
		wait_drained();
		quiet = 1'b0;

		temps = '{16'd1, 16'd300, 16'd1000, 16'd65535, 16'($urandom_range(2, 65534))};
		foreach (temps[i]) begin
			apb_write(3'd0, 32'(temps[i]));
			if (i == 1) begin
				queue_random_sets(100);
				long_hold_go = 1'b1;
				wait_drained();
				send_hold = 1'b1;
				repeat (50) @(posedge clk);
				send_hold = 1'b0;
			end else if (i == 2) begin
				quiet = 1'b1;
				queue_random_sets(160);
				wait_drained();
				quiet = 1'b0;
			end else begin
				queue_random_sets(160);
				wait_drained();
			end
		end
		if (fails == 0)
			$display("** boltzmann_partition_sum_core: PASSED **");
		else
			$display("** boltzmann_partition_sum_core: FAILED **");
		$finish;
	end

	initial begin
		#50_000_000;
		$display("** boltzmann_partition_sum_core: FAILED **");
		$finish;
	end
endmodule

// ----- files.f -----
rtl/bps_pkg.sv
rtl/boltzmann_partition_sum_core.sv
verif/tb.sv
